/* hdl/assert_macros.svh */
// Assertion macros shared by the Hill cipher RTL.
// No dependencies; the assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks that a property holds at every rising clock edge outside reset.
`define HC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hill cipher assertion failed");
// Checks that a condition is never seen at a rising clock edge outside reset.
`define HC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("hill cipher forbidden condition seen");
`else
`define HC_ASSERT(lbl, clk, rst_n, prop)
`define HC_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

/* hdl/hc2_pkg.sv */
// Types, constants and mod-26 helper functions for the 2x2 Hill cipher.
// No dependencies; used by the key register file and the top level.
package hc2_pkg;

    localparam int unsigned ALPHABET = 26;
    // Bias that keeps the determinant sum non-negative.
    localparam int unsigned DET_BIAS = ALPHABET * ALPHABET;
    // floor(2^16 / 26): reciprocal used for the constant division.
    localparam int unsigned RECIP26 = 2520;

    typedef logic [4:0] letter_t;

    typedef enum logic
    {
        CMD_ENCRYPT = 1'b0,
        CMD_DECRYPT = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        REG_KEY_TOP_LEFT     = 2'd0,
        REG_KEY_TOP_RIGHT    = 2'd1,
        REG_KEY_BOTTOM_LEFT  = 2'd2,
        REG_KEY_BOTTOM_RIGHT = 2'd3
    } cfg_index_t;

    typedef struct packed
    {
        letter_t top_left;
        letter_t top_right;
        letter_t bottom_left;
        letter_t bottom_right;
    } key_t;

    // Reduces a 5-bit value into 0..25; one subtraction is enough below 32.
    function automatic letter_t reduce_letter(input logic [4:0] v);
        return (v >= 5'(ALPHABET)) ? v - 5'(ALPHABET) : v;
    endfunction

    // Residue mod 26 of a value up to 1301. The reciprocal estimate of the
    // quotient is low by at most one, so one correction finishes the job.
    function automatic letter_t mod26(input logic [10:0] x);
        logic [21:0] prod;
        logic [5:0]  quot;
        logic [10:0] rem;
        prod = 22'(x) * 22'(RECIP26);
        quot = prod[21:16];
        rem  = x - 11'(quot) * 11'(ALPHABET);
        return (rem >= 11'(ALPHABET)) ? 5'(rem - 11'(ALPHABET)) : 5'(rem);
    endfunction

    // Inverse of a residue mod 26; zero where no inverse exists.
    function automatic letter_t inverse_mod26(input letter_t det);
        letter_t inv;
        case (det)
            5'd1:    inv = 5'd1;
            5'd3:    inv = 5'd9;
            5'd5:    inv = 5'd21;
            5'd7:    inv = 5'd15;
            5'd9:    inv = 5'd3;
            5'd11:   inv = 5'd19;
            5'd15:   inv = 5'd7;
            5'd17:   inv = 5'd23;
            5'd19:   inv = 5'd11;
            5'd21:   inv = 5'd5;
            5'd23:   inv = 5'd17;
            5'd25:   inv = 5'd25;
            default: inv = 5'd0;
        endcase
        return inv;
    endfunction

    // Additive inverse of a residue, itself kept as a residue.
    function automatic letter_t neg_mod26(input letter_t v);
        return (v == 5'd0) ? 5'd0 : 5'(ALPHABET) - v;
    endfunction

endpackage

/* hdl/hc2_if.sv */
// Valid/ready channel interfaces for letter-pair requests and results.
// No dependencies.
interface hc2_pair_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [4:0] first_letter;
    logic [4:0] second_letter;

    modport source (output valid, output command, output first_letter,
                    output second_letter, input ready);
    modport sink   (input valid, input command, input first_letter,
                    input second_letter, output ready);
endinterface

interface hc2_result_if;
    logic       valid;
    logic       ready;
    logic [4:0] first_out;
    logic [4:0] second_out;
    logic       key_not_invertible;

    modport source (output valid, output first_out, output second_out,
                    output key_not_invertible, input ready);
    modport sink   (input valid, input first_out, input second_out,
                    input key_not_invertible, output ready);
endinterface

/* hdl/hc2_key_regs.sv */
// Key matrix register file written through the plain configuration port.
// Depends on hc2_pkg; presents the key already reduced mod 26.
module hc2_key_regs
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  hc2_pkg::cfg_index_t cfg_index,
    input  logic [4:0]         cfg_data,
    output hc2_pkg::key_t      key
);
    import hc2_pkg::*;

    key_t key_reg;
    key_t key_next;

    // Write decode: one register per index.
    always_comb
    begin
        key_next = key_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY_TOP_LEFT:     key_next.top_left     = cfg_data;
                REG_KEY_TOP_RIGHT:    key_next.top_right    = cfg_data;
                REG_KEY_BOTTOM_LEFT:  key_next.bottom_left  = cfg_data;
                REG_KEY_BOTTOM_RIGHT: key_next.bottom_right = cfg_data;
                default:              key_next = key_reg;
            endcase
        end
    end

    // The key resets to the identity matrix.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg.top_left     <= 5'd1;
            key_reg.top_right    <= 5'd0;
            key_reg.bottom_left  <= 5'd0;
            key_reg.bottom_right <= 5'd1;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

    // Values above 25 behave as their residue.
    always_comb
    begin
        key.top_left     = reduce_letter(key_reg.top_left);
        key.top_right    = reduce_letter(key_reg.top_right);
        key.bottom_left  = reduce_letter(key_reg.bottom_left);
        key.bottom_right = reduce_letter(key_reg.bottom_right);
    end

endmodule

/* hdl/hill_cipher_2x2_mod26.sv */
// 2x2 Hill cipher over a 26-letter alphabet; depends on hc2_pkg, hc2_if,
// hc2_key_regs and assert_macros.svh.
// Usage: each request on the pair channel carries a command (encrypt or
// decrypt) and two letter codes; each yields exactly one item on the result
// channel, in order. The key matrix is written through cfg_we, cfg_index and
// cfg_data while no request is in flight, and resets to the identity matrix.
// Decrypting with a key whose determinant has no inverse mod 26 returns zero
// letters with key_not_invertible set.
// A request passes through six register stages in order (key products,
// determinant and inverse lookup, adjugate products, their reduction, the
// matrix-vector products, and the final reduction into the output register);
// the accepting edge loads the first, and the result is presented from the
// output register. One request is accepted every cycle while pair.ready is
// high. Each stage has its own valid bit, so when the receiver stalls the
// pipeline keeps filling its empty stages and lowers pair.ready only once
// all six are full; nothing is dropped or repeated. Reset empties the
// pipeline at once.
`include "assert_macros.svh"

module hill_cipher_2x2_mod26
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  hc2_pkg::cfg_index_t cfg_index,
    input  logic [4:0]          cfg_data,
    hc2_pair_if.sink            pair,
    hc2_result_if.source        result
);
    import hc2_pkg::*;

    key_t key;

    logic [6:1] valid_reg;
    logic [6:1] valid_next;
    logic [6:1] valid_shift;
    logic [6:1] advance;

    // Stage 1: reduced operands and determinant products.
    cmd_t        s1_cmd_reg;
    letter_t     s1_p0_reg, s1_p1_reg;
    key_t        s1_key_reg;
    logic [9:0]  s1_ad_reg, s1_bc_reg;
    // Stage 2: inverse determinant and flag.
    cmd_t        s2_cmd_reg;
    letter_t     s2_p0_reg, s2_p1_reg;
    key_t        s2_key_reg;
    letter_t     s2_inv_reg;
    logic        s2_flag_reg;
    letter_t     s2_inv_next;
    // Stage 3: raw matrix entries.
    logic [9:0]  s3_pr00_reg, s3_pr01_reg, s3_pr10_reg, s3_pr11_reg;
    letter_t     s3_p0_reg, s3_p1_reg;
    logic        s3_flag_reg;
    // Stage 4: reduced matrix entries.
    letter_t     s4_m00_reg, s4_m01_reg, s4_m10_reg, s4_m11_reg;
    letter_t     s4_p0_reg, s4_p1_reg;
    logic        s4_flag_reg;
    // Stage 5: row sums.
    logic [10:0] s5_acc0_reg, s5_acc1_reg;
    logic        s5_flag_reg;
    // Stage 6: output register.
    letter_t     s6_first_reg, s6_second_reg;
    logic        s6_flag_reg;

    hc2_key_regs u_key_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key       (key)
    );

    // A stage moves on when it is empty or the next stage moves on.
    always_comb
    begin
        advance[6] = !valid_reg[6] || result.ready;
        for (int k = 5; k >= 1; k--)
        begin
            advance[k] = !valid_reg[k] || advance[k + 1];
        end
        valid_shift = {valid_reg[5:1], pair.valid};
        valid_next  = (advance & valid_shift) | (~advance & valid_reg);
    end

    assign pair.ready = advance[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Stage 1: reduce the letters and form a*d and b*c.
    always_ff @(posedge clk)
    begin
        if (advance[1] && valid_shift[1])
        begin
            s1_cmd_reg <= cmd_t'(pair.command);
            s1_p0_reg  <= reduce_letter(pair.first_letter);
            s1_p1_reg  <= reduce_letter(pair.second_letter);
            s1_key_reg <= key;
            s1_ad_reg  <= 10'(key.top_left) * 10'(key.bottom_right);
            s1_bc_reg  <= 10'(key.top_right) * 10'(key.bottom_left);
        end
    end

    // Stage 2: determinant mod 26 and its inverse from the table.
    assign s2_inv_next = inverse_mod26(mod26(11'(s1_ad_reg) + 11'(DET_BIAS)
                                             - 11'(s1_bc_reg)));

    always_ff @(posedge clk)
    begin
        if (advance[2] && valid_shift[2])
        begin
            s2_cmd_reg  <= s1_cmd_reg;
            s2_p0_reg   <= s1_p0_reg;
            s2_p1_reg   <= s1_p1_reg;
            s2_key_reg  <= s1_key_reg;
            s2_inv_reg  <= s2_inv_next;
            s2_flag_reg <= (s1_cmd_reg == CMD_DECRYPT) && (s2_inv_next == 5'd0);
        end
    end

    // Stage 3: the key itself, or the adjugate scaled by the inverse.
    always_ff @(posedge clk)
    begin
        if (advance[3] && valid_shift[3])
        begin
            if (s2_cmd_reg == CMD_DECRYPT)
            begin
                s3_pr00_reg <= 10'(s2_key_reg.bottom_right) * 10'(s2_inv_reg);
                s3_pr01_reg <= 10'(neg_mod26(s2_key_reg.top_right)) * 10'(s2_inv_reg);
                s3_pr10_reg <= 10'(neg_mod26(s2_key_reg.bottom_left)) * 10'(s2_inv_reg);
                s3_pr11_reg <= 10'(s2_key_reg.top_left) * 10'(s2_inv_reg);
            end
            else
            begin
                s3_pr00_reg <= 10'(s2_key_reg.top_left);
                s3_pr01_reg <= 10'(s2_key_reg.top_right);
                s3_pr10_reg <= 10'(s2_key_reg.bottom_left);
                s3_pr11_reg <= 10'(s2_key_reg.bottom_right);
            end
            s3_p0_reg   <= s2_p0_reg;
            s3_p1_reg   <= s2_p1_reg;
            s3_flag_reg <= s2_flag_reg;
        end
    end

    // Stage 4: reduce the matrix entries mod 26.
    always_ff @(posedge clk)
    begin
        if (advance[4] && valid_shift[4])
        begin
            s4_m00_reg  <= mod26(11'(s3_pr00_reg));
            s4_m01_reg  <= mod26(11'(s3_pr01_reg));
            s4_m10_reg  <= mod26(11'(s3_pr10_reg));
            s4_m11_reg  <= mod26(11'(s3_pr11_reg));
            s4_p0_reg   <= s3_p0_reg;
            s4_p1_reg   <= s3_p1_reg;
            s4_flag_reg <= s3_flag_reg;
        end
    end

    // Stage 5: matrix times the letter pair.
    always_ff @(posedge clk)
    begin
        if (advance[5] && valid_shift[5])
        begin
            s5_acc0_reg <= 11'(10'(s4_m00_reg) * 10'(s4_p0_reg))
                         + 11'(10'(s4_m01_reg) * 10'(s4_p1_reg));
            s5_acc1_reg <= 11'(10'(s4_m10_reg) * 10'(s4_p0_reg))
                         + 11'(10'(s4_m11_reg) * 10'(s4_p1_reg));
            s5_flag_reg <= s4_flag_reg;
        end
    end

    // Stage 6: final reduction; a singular key gives zero letters.
    always_ff @(posedge clk)
    begin
        if (advance[6] && valid_shift[6])
        begin
            s6_first_reg  <= s5_flag_reg ? 5'd0 : mod26(s5_acc0_reg);
            s6_second_reg <= s5_flag_reg ? 5'd0 : mod26(s5_acc1_reg);
            s6_flag_reg   <= s5_flag_reg;
        end
    end

    assign result.valid              = valid_reg[6];
    assign result.first_out          = s6_first_reg;
    assign result.second_out         = s6_second_reg;
    assign result.key_not_invertible = s6_flag_reg;

    // Checks on the pipeline.
    `HC_ASSERT(a_flag_zeroes, clk, rst_n,
        result.valid && result.key_not_invertible
        |-> (result.first_out == 5'd0) && (result.second_out == 5'd0))
    `HC_ASSERT(a_out_range, clk, rst_n,
        result.valid |-> (result.first_out < 5'd26) && (result.second_out < 5'd26))
    `HC_ASSERT(a_inv_odd, clk, rst_n, valid_reg[2] |-> (s2_inv_reg == 5'd0) || s2_inv_reg[0])
    `HC_ASSERT(a_flag_decrypt, clk, rst_n, valid_reg[2] && s2_flag_reg |-> (s2_cmd_reg == CMD_DECRYPT))
    `HC_ASSERT_NEVER(a_full_accept, clk, rst_n, (&valid_reg) && !result.ready && pair.ready)

endmodule
